/* design/pmhs_pkg.sv */
// ----------------------------------------------------------------------------
// pmhs_pkg: shared definitions of the polar motion harmonic series
// Command codes, sequencer states, fixed-point constants and widths.
// ----------------------------------------------------------------------------
package pmhs_pkg;

	localparam int TERMS_PER_AXIS_DEF = 16;

	localparam int HARM_W  = 8;
	localparam int COEF_W  = 32;
	localparam int TIME_W  = 64;
	localparam int RATE_W  = 64;
	localparam int ANOM_W  = 32;
	localparam int OUT_W   = 40;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 64;
	localparam int TERM_W  = HARM_W + 2 * COEF_W;

	// Operand and product widths of the shared multiplier.
	localparam int OPND_W  = 33;
	localparam int PROD_W  = 2 * OPND_W;

	// Coefficients of the quarter-wave sine polynomial, Q16.
	localparam logic [16:0] POLY_A = 17'd102944;
	localparam logic [16:0] POLY_B = 17'd42048;
	localparam logic [16:0] POLY_C = 17'd4640;

	typedef logic signed [OPND_W-1:0] opnd_t;
	typedef logic signed [PROD_W-1:0] prod_t;

	typedef enum logic [1:0] {
		CMD_LOAD_X = 2'd0,
		CMD_LOAD_Y = 2'd1,
		CMD_EVAL   = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ANOMALY = 1'd0,
		REG_RATE    = 1'd1
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_M0,
		ST_M1,
		ST_M2,
		ST_M3,
		ST_T_CHK,
		ST_T_RD,
		ST_T_PH,
		ST_S_X,
		ST_S_B,
		ST_S_C,
		ST_S_D,
		ST_S_E,
		ST_S_F,
		ST_AXIS_END
	} state_t;

endpackage

/* design/pmhs_if.sv */
// ----------------------------------------------------------------------------
// pmhs_in_if / pmhs_out_if: valid-ready channels of the series block
// One channel carries command words in, the other carries result words out.
// ----------------------------------------------------------------------------
interface pmhs_in_if;
	logic                             valid;
	logic                             ready;
	logic [1:0]                       cmd;
	logic signed [pmhs_pkg::HARM_W-1:0] harmonic;
	logic signed [pmhs_pkg::COEF_W-1:0] cos_coeff;
	logic signed [pmhs_pkg::COEF_W-1:0] sin_coeff;
	logic signed [pmhs_pkg::TIME_W-1:0] epoch_time;

	modport source (output valid, cmd, harmonic, cos_coeff, sin_coeff, epoch_time,
		input ready);
	modport sink (input valid, cmd, harmonic, cos_coeff, sin_coeff, epoch_time,
		output ready);
endinterface

interface pmhs_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [pmhs_pkg::OUT_W-1:0] x_motion;
	logic signed [pmhs_pkg::OUT_W-1:0] y_motion;

	modport source (output valid, x_motion, y_motion, input ready);
	modport sink (input valid, x_motion, y_motion, output ready);
endinterface

/* design/polar_motion_harmonic_series.sv */
// ----------------------------------------------------------------------------
// polar_motion_harmonic_series: two-axis fixed-point harmonic series
// Term tables for X and Y, evaluated with one shared multiplier.
// ----------------------------------------------------------------------------
// Load words append a term (harmonic, cosine and sine coefficient) to the X or
// Y table, and a load into a full table is dropped; a clear word empties both.
// An evaluate word first forms the mean anomaly from three 32 by 32 bit
// partial products of rate and time, then walks every loaded term: one
// multiply for the term phase and, for each of cosine and sine, four
// polynomial multiplies and one coefficient multiply. Every step passes
// through the single registered multiplier, so an evaluate keeps the block
// busy until both axes are done: first the anomaly, then for each term the
// fetch of the term and its phase, cosine and sine, and for each axis the
// loop end and rounding. The result word waits in an output register; load
// and clear words are taken while it waits, and a following evaluate
// finishes only once it has gone. The term tables sit in one RAM of
// 2 * TERMS_PER_AXIS entries with X in the low half; no clearing pass is
// needed since only entries below the term counts are ever read.
// ----------------------------------------------------------------------------
module polar_motion_harmonic_series #(
	parameter int TERMS_PER_AXIS = pmhs_pkg::TERMS_PER_AXIS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pmhs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pmhs_pkg::CFG_DATA_W-1:0]     cfg_data,
	pmhs_in_if.sink                             in_ch,
	pmhs_out_if.source                          out_ch
);
	import pmhs_pkg::*;

	localparam int DEPTH = 2 * TERMS_PER_AXIS;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(TERMS_PER_AXIS + 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(TERMS_PER_AXIS);
	localparam logic [AW-1:0] Y_BASE   = AW'(TERMS_PER_AXIS);
	localparam logic signed [63:0] OUT_MAX = 64'sd549755813887;
	localparam logic signed [63:0] OUT_MIN = -64'sd549755813888;

	// Configuration registers.
	logic [ANOM_W-1:0] anomaly_q;
	logic [RATE_W-1:0] rate_q;

	// Sequencer and datapath registers.
	state_t            state_q, state_d;
	logic [CW-1:0]     x_cnt_q, y_cnt_q;
	logic [CW-1:0]     idx_q;
	logic              axis_q;
	logic              sel_q;      // low: cosine of the term, high: sine
	logic [TIME_W-1:0] time_q;
	logic [31:0]       m_q;
	logic [31:0]       ph_q;
	logic [16:0]       x_q;
	logic [16:0]       x2_q;
	logic              neg_q;
	logic signed [63:0] acc_q;
	logic [COEF_W-1:0] cos_q, sin_q;
	logic              out_valid_q;
	logic signed [OUT_W-1:0] x_res_q, y_res_q, x_out_q, y_out_q;
	// Marks that the multiplier holds a coefficient product to accumulate.
	logic              prev_coef_q;

	// Memory and multiplier connections.
	logic              mem_we;
	logic [AW-1:0]     mem_addr;
	logic [TERM_W-1:0] mem_wdata, mem_rdata;
	opnd_t             mul_a, mul_b;
	prod_t             prod;

	logic              in_fire;
	logic              out_fire;
	logic [CW-1:0]     axis_cnt;
	logic [31:0]       phase_cur;
	logic [16:0]       x_cur;
	logic [17:0]       y_inc;
	logic [15:0]       q_sat;
	logic signed [63:0] rnd;
	logic signed [OUT_W-1:0] axis_res;
	logic              last_ok;

	pmhs_ram #(.WIDTH(TERM_W), .DEPTH(DEPTH)) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.addr (mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	pmhs_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.prod(prod)
	);

	assign in_ch.ready     = (state_q == ST_IDLE);
	assign in_fire         = in_ch.valid && in_ch.ready;
	assign out_ch.valid    = out_valid_q;
	assign out_ch.x_motion = x_out_q;
	assign out_ch.y_motion = y_out_q;
	assign out_fire        = out_valid_q && out_ch.ready;
	assign last_ok         = !out_valid_q || out_ch.ready;

	assign axis_cnt  = axis_q ? y_cnt_q : x_cnt_q;
	// Cosine is the sine a quarter turn further on.
	assign phase_cur = sel_q ? ph_q : ph_q + 32'h4000_0000;
	assign x_cur     = phase_cur[30] ? 17'h10000 - {1'b0, phase_cur[29:14]}
		: {1'b0, phase_cur[29:14]};
	assign y_inc     = {1'b0, prod[32:16]} + 18'd1;
	assign q_sat     = (y_inc[17:1] > 17'd32767) ? 16'd32767 : y_inc[16:1];

	// Round half up at bit 15, then clamp to the 40-bit result range.
	assign rnd      = (acc_q + 64'sd16384) >>> 15;
	assign axis_res = (rnd > OUT_MAX) ? OUT_MAX[OUT_W-1:0]
		: (rnd < OUT_MIN) ? OUT_MIN[OUT_W-1:0] : rnd[OUT_W-1:0];

	assign mem_wdata = {in_ch.harmonic, in_ch.cos_coeff, in_ch.sin_coeff};

	always_comb begin
		state_d  = state_q;
		mem_we   = 1'b0;
		mem_addr = axis_q ? Y_BASE + AW'(idx_q) : AW'(idx_q);
		mul_a    = '0;
		mul_b    = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_ch.valid) begin
					case (cmd_t'(in_ch.cmd))
						CMD_LOAD_X: begin
							mem_addr = AW'(x_cnt_q);
							mem_we   = (x_cnt_q < CNT_FULL);
						end
						CMD_LOAD_Y: begin
							mem_addr = Y_BASE + AW'(y_cnt_q);
							mem_we   = (y_cnt_q < CNT_FULL);
						end
						CMD_EVAL: state_d = ST_M0;
						default: ;
					endcase
				end
			end
			ST_M0: begin
				mul_a   = {1'b0, rate_q[31:0]};
				mul_b   = {1'b0, time_q[31:0]};
				state_d = ST_M1;
			end
			ST_M1: begin
				mul_a   = {1'b0, rate_q[31:0]};
				mul_b   = {1'b0, time_q[63:32]};
				state_d = ST_M2;
			end
			ST_M2: begin
				mul_a   = {1'b0, rate_q[63:32]};
				mul_b   = {1'b0, time_q[31:0]};
				state_d = ST_M3;
			end
			ST_M3: state_d = ST_T_CHK;
			ST_T_CHK: state_d = (idx_q == axis_cnt) ? ST_AXIS_END : ST_T_RD;
			ST_T_RD: state_d = ST_T_PH;
			ST_T_PH: begin
				mul_a   = opnd_t'(signed'(mem_rdata[TERM_W-1 -: HARM_W]));
				mul_b   = {1'b0, m_q};
				state_d = ST_S_X;
			end
			ST_S_X: state_d = ST_S_B;
			ST_S_B: begin
				mul_a   = {16'd0, x_cur};
				mul_b   = {16'd0, x_cur};
				state_d = ST_S_C;
			end
			ST_S_C: begin
				mul_a   = {16'd0, prod[32:16]};
				mul_b   = {16'd0, POLY_C};
				state_d = ST_S_D;
			end
			ST_S_D: begin
				mul_a   = {16'd0, x2_q};
				mul_b   = {16'd0, POLY_B - prod[32:16]};
				state_d = ST_S_E;
			end
			ST_S_E: begin
				mul_a   = {16'd0, x_q};
				mul_b   = {16'd0, POLY_A - prod[32:16]};
				state_d = ST_S_F;
			end
			ST_S_F: begin
				mul_a   = opnd_t'(signed'(sel_q ? sin_q : cos_q));
				mul_b   = neg_q ? -opnd_t'({1'b0, q_sat}) : opnd_t'({1'b0, q_sat});
				state_d = sel_q ? ST_T_CHK : ST_S_X;
			end
			ST_AXIS_END: begin
				if (!axis_q) begin
					state_d = ST_T_CHK;
				end else if (last_ok) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anomaly_q   <= '0;
			rate_q      <= '0;
			x_cnt_q     <= '0;
			y_cnt_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_ANOMALY: anomaly_q <= cfg_data[ANOM_W-1:0];
					REG_RATE:    rate_q    <= cfg_data;
					default: ;
				endcase
			end
			if (in_fire) begin
				case (cmd_t'(in_ch.cmd))
					CMD_LOAD_X: if (x_cnt_q < CNT_FULL) x_cnt_q <= x_cnt_q + 1'b1;
					CMD_LOAD_Y: if (y_cnt_q < CNT_FULL) y_cnt_q <= y_cnt_q + 1'b1;
					CMD_CLEAR: begin
						x_cnt_q <= '0;
						y_cnt_q <= '0;
					end
					default: ;
				endcase
			end
			if (state_q == ST_AXIS_END && axis_q && last_ok) begin
				out_valid_q <= 1'b1;
			end else if (out_fire) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers carry no reset.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				time_q <= in_ch.epoch_time;
				idx_q  <= '0;
				axis_q <= 1'b0;
			end
			ST_M1: m_q <= anomaly_q + prod[63:32];
			ST_M2: m_q <= m_q + prod[31:0];
			ST_M3: begin
				m_q   <= m_q + prod[31:0];
				acc_q <= '0;
			end
			ST_T_PH: begin
				cos_q  <= mem_rdata[2*COEF_W-1 -: COEF_W];
				sin_q  <= mem_rdata[COEF_W-1:0];
				sel_q  <= 1'b0;
			end
			ST_S_X: if (state_d == ST_S_B && !sel_q) ph_q <= prod[31:0];
			ST_S_B: begin
				x_q   <= x_cur;
				neg_q <= phase_cur[31];
			end
			ST_S_C: x2_q <= prod[32:16];
			ST_S_F: ;
			ST_AXIS_END: begin
				if (!axis_q) begin
					x_res_q <= axis_res;
					axis_q  <= 1'b1;
					idx_q   <= '0;
					acc_q   <= '0;
				end else if (last_ok) begin
					x_out_q <= x_res_q;
					y_out_q <= axis_res;
				end
			end
			default: ;
		endcase
		// The coefficient product lands in the cycle after it is issued.
		if ((state_q == ST_T_CHK || state_q == ST_S_X) && prev_coef_q) begin
			acc_q <= acc_q + prod[63:0];
		end
		if (state_q == ST_S_F) begin
			sel_q <= !sel_q;
			if (sel_q) idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_coef_q <= 1'b0;
		end else begin
			prev_coef_q <= (state_q == ST_S_F);
		end
	end

`ifndef SYNTHESIS
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> state_q == ST_IDLE)
		else $error("input taken outside idle");
	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> state_q == ST_IDLE)
		else $error("term store written during an evaluate");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		x_cnt_q <= CNT_FULL && y_cnt_q <= CNT_FULL)
		else $error("term count beyond table size");
	a_term_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_S_F && sel_q) |=> state_q == ST_T_CHK)
		else $error("term did not return to the loop head");
`endif
endmodule

/* design/pmhs_ram.sv */
// ----------------------------------------------------------------------------
// pmhs_ram: generic single-port RAM
// Reads one address per cycle and writes it too when we is high; read data registered.
// ----------------------------------------------------------------------------
module pmhs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

/* design/pmhs_mul.sv */
// ----------------------------------------------------------------------------
// pmhs_mul: shared signed multiplier
// A 33 by 33 bit signed product, registered, result in the cycle after issue.
// ----------------------------------------------------------------------------
module pmhs_mul (
	input  logic            clk,
	input  pmhs_pkg::opnd_t a,
	input  pmhs_pkg::opnd_t b,
	output pmhs_pkg::prod_t prod
);
	always_ff @(posedge clk) begin
		prod <= a * b;
	end
endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench of the polar motion harmonic series
// Loads term tables, evaluates them at random times and anomaly settings,
// and compares each result word with a fixed-point series worked out here.
// ----------------------------------------------------------------------------
module tb_top;
	import pmhs_pkg::*;

	localparam int N_TERMS = TERMS_PER_AXIS_DEF;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic signed [OUT_W-1:0] x_motion;
		logic signed [OUT_W-1:0] y_motion;
	} motion_t;

	// Series model and queue of expected motion words.
	class motion_scoreboard;
		logic [31:0] anomaly;
		logic [63:0] rate;
		logic [7:0]  harm_tab [2*N_TERMS];
		logic [31:0] cos_tab [2*N_TERMS];
		logic [31:0] sin_tab [2*N_TERMS];
		int          n_x;
		int          n_y;
		motion_t     pending_motion [$];
		int          errors;

		function void clear_all();
			anomaly = '0;
			rate = '0;
			n_x = 0;
			n_y = 0;
			errors = 0;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [63:0] val);
			if (idx == REG_ANOMALY)
				anomaly = val[31:0];
			else
				rate = val;
		endfunction

		// Quarter-wave polynomial, Q16 in and out.
		function logic [63:0] quarter_wave(logic [63:0] x);
			logic [63:0] x2, t, u;
			x2 = (x * x) >> 16;
			t = 64'(POLY_B) - ((x2 * 64'(POLY_C)) >> 16);
			u = 64'(POLY_A) - ((x2 * t) >> 16);
			return (x * u) >> 16;
		endfunction

		function longint sine15(logic [31:0] phase);
			logic [63:0] x, q;
			x = 64'(phase[29:14]);
			if (phase[30])
				x = 64'd65536 - x;
			q = (quarter_wave(x) + 1) >> 1;
			if (q > 32767)
				q = 32767;
			return phase[31] ? -longint'(q) : longint'(q);
		endfunction

		function logic signed [OUT_W-1:0] axis_total(int base, int cnt, logic [31:0] m);
			longint acc;
			longint r;
			logic [31:0] ph;
			acc = 0;
			for (int i = 0; i < cnt; i++) begin
				ph = 32'(signed'(harm_tab[base+i])) * m;
				acc += longint'(signed'(cos_tab[base+i])) * sine15(ph + 32'h4000_0000);
				acc += longint'(signed'(sin_tab[base+i])) * sine15(ph);
			end
			// Floor division by 2^15 after adding half; >>> floors on signed values.
			r = (acc + 16384) >>> 15;
			if (r > 64'sd549755813887)
				r = 64'sd549755813887;
			if (r < -64'sd549755813888)
				r = -64'sd549755813888;
			return r[OUT_W-1:0];
		endfunction

		function void note_word(cmd_t c, logic [7:0] h, logic [31:0] cc, logic [31:0] sc,
				logic [63:0] t);
			logic [63:0] prod;
			logic [31:0] m;
			motion_t mv;
			case (c)
				CMD_LOAD_X, CMD_LOAD_Y: begin
					if (c == CMD_LOAD_X && n_x < N_TERMS) begin
						harm_tab[n_x] = h; cos_tab[n_x] = cc; sin_tab[n_x] = sc;
						n_x++;
					end else if (c == CMD_LOAD_Y && n_y < N_TERMS) begin
						harm_tab[N_TERMS+n_y] = h; cos_tab[N_TERMS+n_y] = cc;
						sin_tab[N_TERMS+n_y] = sc;
						n_y++;
					end
				end
				CMD_CLEAR: begin
					n_x = 0;
					n_y = 0;
				end
				default: begin
					prod = rate * t;
					m = anomaly + prod[63:32];
					mv.x_motion = axis_total(0, n_x, m);
					mv.y_motion = axis_total(N_TERMS, n_y, m);
					pending_motion.push_back(mv);
				end
			endcase
		endfunction

		task report(string what);
			$display("mismatch at %0t: %s", $realtime, what);
			errors++;
		endtask

		task check_word(logic signed [OUT_W-1:0] xm, logic signed [OUT_W-1:0] ym);
			motion_t e;
			if (pending_motion.size() == 0) begin
				report("result word with nothing expected");
				return;
			end
			e = pending_motion.pop_front();
			if (xm !== e.x_motion)
				report($sformatf("x_motion got %0d want %0d", xm, e.x_motion));
			if (ym !== e.y_motion)
				report($sformatf("y_motion got %0d want %0d", ym, e.y_motion));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	pmhs_in_if  in_ch ();
	pmhs_out_if out_ch ();

	polar_motion_harmonic_series u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_ch    (in_ch.sink),
		.out_ch   (out_ch.source)
	);

	motion_scoreboard sb;
	int idle_cycles;
	int stall_mode;	// selects the receiver's stall pattern

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Receiver: each accepted result word is checked at the edge where it is
	// taken. The stall pattern changes per phase, including no stalls at all.
	initial begin
		int ph;
		ph = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_ch.valid && out_ch.ready)
				sb.check_word(out_ch.x_motion, out_ch.y_motion);
			ph++;
			case (stall_mode)
				0: out_ch.ready <= 1'b1;
				1: out_ch.ready <= ($urandom_range(0, 3) != 0);
				2: out_ch.ready <= (ph % 7) < 2;
				default: out_ch.ready <= ($urandom_range(0, 9) == 0);
			endcase
		end
	end

	// Watchdog: counts cycles with no word accepted on either channel.
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("polar_motion_harmonic_series verification failed");
				$finish;
			end
		end
	end

	// Sender burst state: the words left in the current burst before the next gap.
	int burst_left;

	// Hand one word to the block and hold it until accepted. Valid stays high
	// across back-to-back words within a burst.
	task send_word(cmd_t c, logic [7:0] h, logic [31:0] cc, logic [31:0] sc, logic [63:0] t);
		if (burst_left <= 0) begin
			repeat ($urandom_range(1, 6)) begin
				in_ch.valid <= 1'b0;
				@(posedge clk);
			end
			burst_left = $urandom_range(0, 1) ? $urandom_range(1, 40) : $urandom_range(1, 4);
		end
		burst_left--;
		in_ch.valid      <= 1'b1;
		in_ch.cmd        <= c;
		in_ch.harmonic   <= h;
		in_ch.cos_coeff  <= cc;
		in_ch.sin_coeff  <= sc;
		in_ch.epoch_time <= t;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_word(c, h, cc, sc, t);
	endtask

	task drop_valid();
		in_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Wait for every expected word, then a settling margin for trailing work.
	task drain();
		drop_valid();
		while (sb.pending_motion.size() != 0)
			@(posedge clk);
		repeat (500) @(posedge clk);
	endtask

	task write_reg(cfg_reg_t idx, logic [63:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		sb.set_reg(idx, val);
		@(posedge clk);
	endtask

	function logic [63:0] rnd64();
		return {$urandom(), $urandom()};
	endfunction

	// Coefficients: moderate half the time, else the two extremes or a full-range value.
	function logic [31:0] rnd_coeff();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return $urandom();
			default: return 32'($urandom_range(0, 200000)) - 32'd100000;
		endcase
	endfunction

	task send_load(cmd_t c);
		send_word(c, 8'($urandom()), rnd_coeff(), rnd_coeff(), rnd64());
	endtask

	task send_eval(logic [63:0] t);
		send_word(CMD_EVAL, 8'($urandom()), $urandom(), $urandom(), t);
	endtask

	initial begin
		int   r;
		sb = new();
		sb.clear_all();
		stall_mode = 0;
		burst_left = 0;
		cfg_we = 1'b0;
		cfg_index = REG_ANOMALY;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.cmd = CMD_CLEAR;
		in_ch.harmonic = '0;
		in_ch.cos_coeff = '0;
		in_ch.sin_coeff = '0;
		in_ch.epoch_time = '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: evaluation of empty tables, field extremes, a full table
		// with dropped loads, repeated harmonics, and a clear.
		send_eval(64'h0);
		send_word(CMD_LOAD_X, 8'h80, 32'h8000_0000, 32'h7fff_ffff, 64'h0);
		send_word(CMD_LOAD_X, 8'h7f, 32'h7fff_ffff, 32'h8000_0000, 64'hffff_ffff_ffff_ffff);
		send_word(CMD_LOAD_Y, 8'h01, 32'd1000, 32'd1000, 64'h0);
		send_word(CMD_LOAD_Y, 8'h01, 32'd1000, 32'hffff_fc18, 64'h0);
		send_eval(64'h8000_0000_0000_0000);
		send_eval(64'h7fff_ffff_ffff_ffff);
		drain();
		write_reg(REG_RATE, 64'hffff_ffff_ffff_ffff);
		write_reg(REG_ANOMALY, 32'hffff_ffff);
		// Overfill X with maximal coefficients so the extra loads are dropped.
		for (int i = 0; i < N_TERMS + 2; i++)
			send_word(CMD_LOAD_X, 8'h00, 32'h7fff_ffff, 32'h7fff_ffff, 64'h0);
		send_eval(64'h1);
		send_eval(64'hffff_ffff_ffff_fffe);
		send_word(CMD_CLEAR, 8'hff, 32'hffff_ffff, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff);
		send_eval(64'h5555_aaaa_5555_aaaa);
		drain();

		// Random phases: per phase new register values (extremes among them),
		// a new stall pattern, then table fills, evaluates and clears.
		for (int p = 0; p < 12; p++) begin
			stall_mode = p % 4;
			write_reg(REG_ANOMALY, (p == 1) ? 64'h0 : (p == 2) ? 64'hffff_ffff : rnd64());
			write_reg(REG_RATE, (p == 1) ? 64'h0 : (p == 2) ? 64'hffff_ffff_ffff_ffff : rnd64());
			for (int n = 0; n < 125; n++) begin
				r = $urandom_range(0, 99);
				if (r < 45)
					send_load($urandom_range(0, 1) ? CMD_LOAD_X : CMD_LOAD_Y);
				else if (r < 95)
					send_eval(rnd64());
				else
					send_word(CMD_CLEAR, 8'($urandom()), $urandom(), $urandom(), rnd64());
			end
			drain();
		end

		if (sb.errors == 0 && sb.pending_motion.size() == 0)
			$display("polar_motion_harmonic_series verification clean");
		else
			$display("polar_motion_harmonic_series verification failed");
		$finish;
	end
endmodule
